// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, suspended while rst is high.
`define PCBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clk edge, including reset cycles.
`define PCBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pcbp_pkg.sv
// Shared types, codes and constants of the prefix-code bit packer.
`default_nettype none
package pcbp_pkg;

  localparam int MAX_CODE_BITS = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int PAD_BITS = 7;
  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam logic [7:0] RESET_END_SYMBOL = 8'd3;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic residual_ok;
  } back_stat_t;

  function automatic int code_width(input int max_bits);
    return (max_bits < WORD_BITS) ? max_bits : WORD_BITS;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/prefix_code_bit_packer_top.sv
// Prefix-code bit packer: loads a code table and packs symbol codes into bytes.
//
// Input channel (in_valid/in_ready, in_item): one transaction per cycle when
// in_ready is high. A load writes one table entry; an encode appends the
// symbol's code; a finish appends the end symbol's code, pads the partial byte
// with zeros and empties the accumulator. Output channel (out_valid/out_ready,
// out_item): packed bytes, earliest bit in bit 7, last_of_run set on the final
// byte of a transaction. cfg_we/cfg_wdata write end_symbol; write only while
// the block is idle. Codes pass lookup, queue, accumulator and output register.
// Throughput: one transaction per cycle while out_ready is high and each makes
// at most one byte; the packer emits a byte per cycle while out_ready is high
// and holds longer ones to the last byte; the two-entry queue and lookup stage
// absorb the difference before in_ready drops. Loads only touch the table.
// Reset: synchronous; the table reads as empty right away (per-entry loaded
// flags), accumulator empty, end_symbol = 3. No clearing pass.
// A stalled receiver holds the output register, then the packer, the queue
// and finally in_ready.
`default_nettype none
`include "assert_macros.svh"
module prefix_code_bit_packer_top #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS,
  parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pcbp_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pcbp_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata
);

  localparam int CodeW = pcbp_pkg::code_width(MAX_CODE_BITS);
  localparam int LenW = $clog2(CodeW + 1);
  localparam int EntW = CodeW + LenW;

  logic [7:0]           end_symbol;
  logic                 q_push_valid;
  logic                 q_push_ready;
  logic [EntW:0]        q_push_data;
  logic                 q_pop_valid;
  logic                 q_pop_ready;
  logic [EntW:0]        q_pop_data;
  pcbp_pkg::back_stat_t back_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_symbol <= pcbp_pkg::RESET_END_SYMBOL;
    end else if (cfg_we) begin
      end_symbol <= cfg_wdata;
    end
  end

  pcbp_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .end_symbol(end_symbol),
    .q_valid   (q_push_valid),
    .q_ready   (q_push_ready),
    .q_data    (q_push_data)
  );

  pcbp_fifo #(
    .WIDTH(EntW + 1),
    .DEPTH(pcbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  pcbp_back #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_pop_valid),
    .q_ready  (q_pop_ready),
    .q_data   (q_pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .stat     (back_stat)
  );

  `PCBP_ASSERT(a_idle_residual, !back_stat.busy |-> back_stat.residual_ok,
               "idle packer holds a full byte")
  `PCBP_ASSERT(a_lookup_hold,
               q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data),
               "lookup stage lost data on stall")
  `PCBP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid && !back_stat.busy,
                      "output or packer active after reset")

endmodule
`default_nettype wire

// File: hw/rtl/pcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pcbp_front.sv
// Front end: accepts transactions, keeps the code table, looks up codes for the queue.
`default_nettype none
module pcbp_front #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS,
  parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT,
  localparam int CodeW = pcbp_pkg::code_width(MAX_CODE_BITS),
  localparam int LenW = $clog2(CodeW + 1),
  localparam int EntW = CodeW + LenW
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pcbp_pkg::in_item_t   in_item,
  input  wire logic [7:0]           end_symbol,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output logic      [EntW:0]        q_data
);

  localparam int AddrW = $clog2(SYMBOL_COUNT);

  logic              accept;
  logic              is_load;
  logic              is_lookup;
  logic [7:0]        addr_sym;
  logic              in_range;
  logic [LenW-1:0]   len_sat;
  logic [CodeW-1:0]  code_mask;
  logic [CodeW-1:0]  code_masked;
  logic              tbl_we;
  logic [EntW-1:0]   rd_data;
  logic [SYMBOL_COUNT-1:0] loaded;
  logic              s1_valid;
  logic              s1_fin;
  logic              s1_hit;
  logic [LenW-1:0]   rd_len;
  logic [CodeW-1:0]  rd_code;
  logic [LenW:0]     shamt;
  logic [CodeW-1:0]  code_al;

  assign in_ready = !s1_valid || q_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    is_load = 1'b0;
    is_lookup = 1'b0;
    case (in_item.opcode)
      pcbp_pkg::OP_LOAD: begin
        is_load = 1'b1;
      end
      pcbp_pkg::OP_ENCODE, pcbp_pkg::OP_FINISH: begin
        is_lookup = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign addr_sym = (in_item.opcode == pcbp_pkg::OP_FINISH) ? end_symbol : in_item.symbol;
  assign in_range = {1'b0, addr_sym} < 9'(SYMBOL_COUNT);

  assign len_sat = (in_item.code_len > 6'(CodeW)) ? LenW'(CodeW)
                                                  : in_item.code_len[LenW-1:0];

  always_comb begin
    for (int i = 0; i < CodeW; i++) begin
      code_mask[i] = i < int'(len_sat);
    end
  end

  assign code_masked = in_item.code_bits[CodeW-1:0] & code_mask;
  assign tbl_we = accept && is_load && in_range;

  pcbp_ram #(
    .WIDTH(EntW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(addr_sym[AddrW-1:0]),
    .wdata({len_sat, code_masked}),
    .re   (accept && is_lookup),
    .raddr(addr_sym[AddrW-1:0]),
    .rdata(rd_data)
  );

  // Table empties at reset through the loaded flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (tbl_we) begin
      loaded[addr_sym[AddrW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_lookup) begin
      s1_valid <= 1'b1;
    end else if (q_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_lookup) begin
      s1_fin <= in_item.opcode == pcbp_pkg::OP_FINISH;
      s1_hit <= in_range && loaded[addr_sym[AddrW-1:0]];
    end
  end

  assign rd_len = s1_hit ? rd_data[EntW-1 -: LenW] : '0;
  assign rd_code = s1_hit ? rd_data[CodeW-1:0] : '0;
  // Left-align the code word so the back end only shifts by the pending fill.
  assign shamt = (LenW + 1)'(CodeW) - {1'b0, rd_len};
  assign code_al = rd_code << shamt;

  assign q_valid = s1_valid;
  assign q_data = {s1_fin, rd_len, code_al};

endmodule
`default_nettype wire

// File: hw/rtl/pcbp_fifo.sv
// Small register FIFO between the front end and the packer.
`default_nettype none
module pcbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcbp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;
  logic             pop;

  assign push_ready = count != CntW'(DEPTH);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pcbp_back.sv
// Back end: bit accumulator that packs queued codes into bytes, MSB first.
`default_nettype none
module pcbp_back #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS,
  localparam int CodeW = pcbp_pkg::code_width(MAX_CODE_BITS),
  localparam int LenW = $clog2(CodeW + 1),
  localparam int EntW = CodeW + LenW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire logic [EntW:0]         q_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pcbp_pkg::out_item_t        out_item,
  output pcbp_pkg::back_stat_t       stat
);

  localparam int AccW = CodeW + pcbp_pkg::PAD_BITS;
  localparam int TotW = $clog2(AccW + 1);
  localparam int ByteB = pcbp_pkg::BYTE_BITS;

  logic             busy;
  logic             fin;
  logic [AccW-1:0]  acc;
  logic [TotW-1:0]  total;
  logic             has_byte;
  logic             is_last;
  logic             emit;
  logic             retire;
  logic             pop;
  logic [AccW-1:0]  acc_e;
  logic [TotW-1:0]  total_e;
  logic             q_fin;
  logic [LenW-1:0]  q_len;
  logic [CodeW-1:0] q_code;
  logic [AccW-1:0]  merged;

  assign q_fin = q_data[EntW];
  assign q_len = q_data[EntW-1 -: LenW];
  assign q_code = q_data[CodeW-1:0];

  // acc holds pending bits left-aligned; bits below total are zero.
  assign has_byte = busy && (int'(total) >= ByteB || (fin && total != '0));
  assign is_last = fin ? (int'(total) <= ByteB) : (int'(total) < 2 * ByteB);
  assign emit = has_byte && (!out_valid || out_ready);
  assign acc_e = emit ? (acc << ByteB) : acc;
  assign total_e = !emit ? total :
                   (int'(total) >= ByteB) ? total - TotW'(ByteB) : '0;
  assign retire = busy && (!has_byte || (emit && is_last));
  assign q_ready = !busy || retire;
  assign pop = q_valid && q_ready;
  assign merged = {q_code, {pcbp_pkg::PAD_BITS{1'b0}}} >> total_e[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      acc <= '0;
      total <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      fin <= q_fin;
      acc <= acc_e | merged;
      total <= total_e + TotW'(q_len);
    end else begin
      busy <= busy && !retire;
      acc <= acc_e;
      total <= total_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.out_byte <= acc[AccW-1 -: ByteB];
      out_item.last_of_run <= is_last;
    end
  end

  assign stat.busy = busy;
  assign stat.residual_ok = int'(total) < ByteB;

endmodule
`default_nettype wire
